@@ hdl/elfi_pkg.sv @@
package elfi_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned GateBitsDef   = 24;

  localparam int unsigned CfgW    = 24;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [23:0] OnePhase    = 24'h01_0000;
  localparam logic [24:0] FreezePhase = 25'h0FE_0000;
  localparam logic [24:0] WrapPhase   = 25'h100_0000;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_TABLE_WR = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STAGE_LEVELS = 3'd0,
    CFG_STEP_ATTACK  = 3'd1,
    CFG_STEP_DECAY   = 3'd2,
    CFG_STEP_SUSTAIN = 3'd3,
    CFG_STEP_RELEASE = 3'd4,
    CFG_LFO_STEP     = 3'd5,
    CFG_FILTER_SETUP = 3'd6,
    CFG_LFO_ONE_SHOT = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STG_ATTACK  = 2'd0,
    STG_DECAY   = 2'd1,
    STG_SUSTAIN = 2'd2,
    STG_RELEASE = 2'd3
  } stage_e;

  // table write request, index still in the raw 8-bit item form
  typedef struct packed {
    logic              en;
    logic [7:0]        idx;
    logic signed [7:0] val;
  } tbl_wr_t;

  function automatic logic [7:0] level_of(logic [23:0] levels, stage_e s);
    logic [7:0] lvl;
    case (s)
      STG_ATTACK:  lvl = levels[7:0];
      STG_DECAY:   lvl = levels[15:8];
      STG_SUSTAIN: lvl = levels[23:16];
      default:     lvl = 8'd0;
    endcase
    return lvl;
  endfunction

endpackage

@@ hdl/envelope_lfo_filter_index.sv @@
// channel   dir  handshake                     payload
// cfg       in   cfg_we_i (no backpressure)    cfg_idx_i, cfg_data_i
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: gate, index, value; tuser: cmd
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: level, bank, mod, stage, finished
//
// One item per clock sustained while the output is not stalled; items pass through the input
// register and then the result register. The whole tick update and the filter index fit between those two registers.
// The LFO table entry for the current phase is prefetched into the read register of the
// table RAM. Reset clears the pipeline valids, state and config; no clear pass.
// A stalled output holds its item while one more item waits in the input register.
module envelope_lfo_filter_index #(
  parameter int unsigned TABLE_DEPTH = elfi_pkg::TableDepthDef,
  parameter int unsigned GATE_BITS   = elfi_pkg::GateBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [elfi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [elfi_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // gate_length[23:0], table_index[31:24], table_value[39:32]
  input  logic [39:0]                    s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // envelope_level[7:0], filter_bank[13:8], lfo_mod[21:14], stage[23:22],
  // finished[24], zero[31:25]
  output logic [31:0]                    m_axis_tdata
);
  import elfi_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  // configuration
  logic [23:0]       levels_q;
  logic [23:0]       step_q [4];
  logic [23:0]       lfo_step_q;
  logic [23:0]       filt_q;
  logic              one_shot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q   <= '0;
      step_q     <= '{default: '0};
      lfo_step_q <= '0;
      filt_q     <= '0;
      one_shot_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STAGE_LEVELS: levels_q   <= cfg_data_i;
        CFG_STEP_ATTACK:  step_q[0]  <= cfg_data_i;
        CFG_STEP_DECAY:   step_q[1]  <= cfg_data_i;
        CFG_STEP_SUSTAIN: step_q[2]  <= cfg_data_i;
        CFG_STEP_RELEASE: step_q[3]  <= cfg_data_i;
        CFG_LFO_STEP:     lfo_step_q <= cfg_data_i;
        CFG_FILTER_SETUP: filt_q     <= cfg_data_i;
        CFG_LFO_ONE_SHOT: one_shot_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_vld_q;
  logic [1:0]        in_cmd_q;
  logic [23:0]       in_gate_q;
  logic [7:0]        in_tidx_q;
  logic signed [7:0] in_tval_q;
  logic              out_vld_q;
  logic [31:0]       out_data_q;
  logic              fire;

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_gate_q <= s_axis_tdata[23:0];
      in_tidx_q <= s_axis_tdata[31:24];
      in_tval_q <= $signed(s_axis_tdata[39:32]);
    end
  end

  // voice state
  logic [23:0]          env_q, env_d;
  stage_e               stage_q, stage_d;
  logic [GATE_BITS-1:0] gate_q, gate_d;
  logic [23:0]          phase_q, phase_d;
  logic                 frozen_q, frozen_d;
  logic signed [7:0]    held_q, held_d;

  // table RAM
  tbl_wr_t           tbl_wr;
  logic [AddrW+7:0]  rd_wide;
  logic [AddrW-1:0]  rd_addr;
  logic signed [7:0] tbl_rd;
  logic signed [7:0] tbl_frz;

  assign rd_wide = {AddrW'(0), phase_d[23:16]};
  assign rd_addr = rd_wide[AddrW-1:0];

  elfi_mod_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mod_table (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (tbl_rd),
    .frz_data_o (tbl_frz)
  );

  // tick datapath
  stage_e               stg_t;
  logic [23:0]          tgt;
  logic [23:0]          spd;
  logic [23:0]          env_gap;
  logic                 lfo_run;
  logic [24:0]          ph_sum;
  logic [GATE_BITS+23:0] gate_wide;

  assign stg_t   = (gate_q == '0 && stage_q != STG_RELEASE) ? STG_RELEASE : stage_q;
  assign tgt     = {level_of(levels_q, stg_t), 16'h0000};
  assign spd     = step_q[stg_t];
  assign env_gap = (env_q > tgt) ? env_q - tgt : tgt - env_q;
  assign lfo_run = (lfo_step_q != '0) && !frozen_q;
  assign ph_sum  = {1'b0, phase_q} + {1'b0, lfo_step_q};
  assign gate_wide = {GATE_BITS'(0), in_gate_q};

  always_comb begin
    env_d    = env_q;
    stage_d  = stage_q;
    gate_d   = gate_q;
    phase_d  = phase_q;
    frozen_d = frozen_q;
    held_d   = held_q;
    tbl_wr   = '0;
    if (fire) begin
      case (cmd_e'(in_cmd_q))
        CMD_TICK: begin
          stage_d = stg_t;
          if (env_gap <= spd) begin
            env_d = tgt;
            if (stg_t == STG_ATTACK) begin
              stage_d = STG_DECAY;
            end else if (stg_t == STG_DECAY) begin
              stage_d = STG_SUSTAIN;
            end
          end else if (env_q < tgt) begin
            env_d = env_q + spd;
          end else begin
            env_d = env_q - spd;
          end
          if (lfo_run) begin
            held_d  = tbl_rd;
            phase_d = ph_sum[23:0];
            if (one_shot_q && ph_sum >= FreezePhase) begin
              phase_d  = FreezePhase[23:0];
              frozen_d = 1'b1;
              held_d   = tbl_frz;
            end
            // in loop mode the sum wraps past 256.0 by dropping bit 24
          end
          if (gate_q != '0) begin
            gate_d = gate_q - GATE_BITS'(1);
          end
        end
        CMD_NOTE_ON: begin
          gate_d   = gate_wide[GATE_BITS-1:0];
          env_d    = '0;
          stage_d  = STG_ATTACK;
          phase_d  = '0;
          frozen_d = 1'b0;
          held_d   = '0;
        end
        CMD_TABLE_WR: begin
          tbl_wr.en  = ({3'b000, in_tidx_q} < 11'(TABLE_DEPTH));
          tbl_wr.idx = in_tidx_q;
          tbl_wr.val = in_tval_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q    <= '0;
      stage_q  <= STG_ATTACK;
      gate_q   <= '0;
      phase_q  <= '0;
      frozen_q <= 1'b0;
      held_q   <= '0;
    end else begin
      env_q    <= env_d;
      stage_q  <= stage_d;
      gate_q   <= gate_d;
      phase_q  <= phase_d;
      frozen_q <= frozen_d;
      held_q   <= held_d;
    end
  end

  // result from the state after the item
  logic [7:0]         lvl;
  logic [15:0]        env_prod;
  logic signed [16:0] mod_prod;
  logic signed [8:0]  mod_floor;
  logic signed [9:0]  mod_term;
  logic signed [9:0]  filt_raw;
  logic [7:0]         filt_clamp;
  logic               fin;

  assign lvl       = env_d[23:16];
  assign env_prod  = lvl * filt_q[15:8];
  assign mod_prod  = held_d * $signed({1'b0, filt_q[23:16]});
  assign mod_floor = mod_prod[16:8];
  // divide by 256 rounds toward zero: bump negative values with a remainder
  assign mod_term  = 10'(mod_floor) +
                     ((mod_prod[16] && mod_prod[7:0] != 8'h00) ? 10'sd1 : 10'sd0);
  assign filt_raw  = 10'sd255 - $signed({2'b00, filt_q[7:0]})
                     - $signed({2'b00, env_prod[15:8]}) + mod_term;

  always_comb begin
    if (filt_raw < 10'sd0) begin
      filt_clamp = 8'd0;
    end else if (filt_raw > 10'sd255) begin
      filt_clamp = 8'd255;
    end else begin
      filt_clamp = filt_raw[7:0];
    end
  end

  assign fin = (env_d <= OnePhase) &&
               (stage_d == STG_RELEASE || level_of(levels_q, stage_d) == 8'd0);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {7'd0, fin, stage_d, held_d, filt_clamp[7:2], lvl};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ hdl/elfi_mod_table.sv @@
module elfi_mod_table #(
  parameter int unsigned TABLE_DEPTH = elfi_pkg::TableDepthDef
) (
  input  logic                     clk_i,
  input  elfi_pkg::tbl_wr_t        wr_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_i,
  output logic signed [7:0]        rd_data_o,
  output logic signed [7:0]        frz_data_o
);
  import elfi_pkg::*;

  localparam int unsigned AddrW  = $clog2(TABLE_DEPTH);
  localparam int unsigned FrzIdx = 254 % TABLE_DEPTH;

  logic signed [7:0] mem [TABLE_DEPTH];
  logic [AddrW+7:0]  wr_wide;
  logic [AddrW-1:0]  wr_addr;
  logic signed [7:0] rd_q;
  logic signed [7:0] frz_q;

  assign wr_wide = {AddrW'(0), wr_i.idx};
  assign wr_addr = wr_wide[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_i.val;
    end
  end

  // write-first: the prefetch for the next item must see a write to the same entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_addr == rd_addr_i) begin
      rd_q <= wr_i.val;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // shadow copy of the freeze entry, used in the same cycle as the phase entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_addr == AddrW'(FrzIdx)) begin
      frz_q <= wr_i.val;
    end
  end

  assign rd_data_o  = rd_q;
  assign frz_data_o = frz_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import elfi_pkg::*;

  localparam logic [1:0]  CmdUnused   = 2'd3;
  localparam int unsigned EnvOne      = 32'h1_0000;
  localparam int unsigned PhaseFreeze = 254 * EnvOne;
  localparam int unsigned PhaseWrap   = 256 * EnvOne;
  localparam int unsigned FreezeEntry = 254;
  localparam int unsigned ModDepth    = 256;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned HoldEvery   = 700;
  localparam int unsigned MaxReports  = 30;

  typedef struct {
    logic [7:0]        level;
    logic [5:0]        bank;
    logic signed [7:0] mod;
    stage_e            stage;
    logic              finished;
  } voice_out_t;

  // Tracks envelope/LFO state and holds the results still owed by the block.
  class voice_scoreboard;
    logic [23:0]       regs [8];
    int unsigned       env;
    int unsigned       gate_cnt;
    int unsigned       phase;
    stage_e            stg;
    bit                frozen;
    int                held;
    logic signed [7:0] mod_tbl [ModDepth];
    voice_out_t        owed_q [$];
    int unsigned       errors, checked;
    int unsigned       n_tick, n_note, n_wr, n_unused, n_freeze, n_gate_rel;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mod_tbl[i]) mod_tbl[i] = '0;
      env = 0;
      gate_cnt = 0;
      phase = 0;
      stg = STG_ATTACK;
      frozen = 1'b0;
      held = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [23:0] v);
      regs[idx] = (idx == CFG_LFO_ONE_SHOT) ? {23'd0, v[0]} : v;
    endfunction

    function logic [7:0] target_of(stage_e s);
      case (s)
        STG_ATTACK:  return regs[CFG_STAGE_LEVELS][7:0];
        STG_DECAY:   return regs[CFG_STAGE_LEVELS][15:8];
        STG_SUSTAIN: return regs[CFG_STAGE_LEVELS][23:16];
        default:     return 8'd0;
      endcase
    endfunction

    function logic [23:0] step_of(stage_e s);
      case (s)
        STG_ATTACK:  return regs[CFG_STEP_ATTACK];
        STG_DECAY:   return regs[CFG_STEP_DECAY];
        STG_SUSTAIN: return regs[CFG_STEP_SUSTAIN];
        default:     return regs[CFG_STEP_RELEASE];
      endcase
    endfunction

    function void advance_tick();
      int unsigned target, spd, env_gap;
      int          m;
      n_tick++;
      if (gate_cnt == 0 && stg != STG_RELEASE) begin
        stg = STG_RELEASE;
        n_gate_rel++;
      end
      target = {8'd0, target_of(stg), 16'd0};
      spd = {8'd0, step_of(stg)};
      env_gap = (env > target) ? env - target : target - env;
      if (env_gap <= spd) begin
        env = target;
        if (stg == STG_ATTACK) begin
          stg = STG_DECAY;
        end else if (stg == STG_DECAY) begin
          stg = STG_SUSTAIN;
        end
      end else if (env < target) begin
        env += spd;
      end else begin
        env -= spd;
      end
      // LFO: sample the entry at the old phase, then move the phase
      if (regs[CFG_LFO_STEP] != 0 && !frozen) begin
        m = mod_tbl[8'((phase >> 16) % ModDepth)];
        phase += {8'd0, regs[CFG_LFO_STEP]};
        if (regs[CFG_LFO_ONE_SHOT][0] && phase >= PhaseFreeze) begin
          phase = PhaseFreeze;
          frozen = 1'b1;
          n_freeze++;
          m = mod_tbl[8'(FreezeEntry % ModDepth)];
        end else if (!regs[CFG_LFO_ONE_SHOT][0] && phase >= PhaseWrap) begin
          phase -= PhaseWrap;
        end
        held = m;
      end
      if (gate_cnt > 0) gate_cnt--;
    endfunction

    function voice_out_t voice_outputs();
      voice_out_t  o;
      int unsigned lvl;
      int          base, edep, mdep, f;
      lvl = env >> 16;
      if (lvl > 255) lvl = 255;
      base = int'(regs[CFG_FILTER_SETUP][7:0]);
      edep = int'(regs[CFG_FILTER_SETUP][15:8]);
      mdep = int'(regs[CFG_FILTER_SETUP][23:16]);
      f = (255 - base) - ((int'(lvl) * edep) >>> 8) + (held * mdep) / 256;
      if (f < 0) f = 0;
      if (f > 255) f = 255;
      o.level = lvl[7:0];
      o.bank = f[7:2];
      o.mod = held[7:0];
      o.stage = stg;
      o.finished = (env <= EnvOne) && (stg == STG_RELEASE || target_of(stg) == 8'd0);
      return o;
    endfunction

    function void take_item(logic [1:0] cmd, logic [39:0] d);
      case (cmd)
        CMD_TICK: advance_tick();
        CMD_NOTE_ON: begin
          n_note++;
          gate_cnt = {8'd0, d[23:0]};
          env = 0;
          stg = STG_ATTACK;
          phase = 0;
          frozen = 1'b0;
          held = 0;
        end
        CMD_TABLE_WR: begin
          n_wr++;
          mod_tbl[d[31:24]] = d[39:32];
        end
        default: n_unused++;
      endcase
      owed_q.insert(owed_q.size(), voice_outputs());
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MaxReports) $display("%0t: %s", $time, msg);
    endfunction

    function void compare(string what, int exp, int act);
      if (exp != act)
        flag($sformatf("%s mismatch: expected %0d, actual %0d", what, exp, act));
    endfunction

    function void check_out(logic [31:0] d);
      voice_out_t e;
      if (owed_q.size() == 0) begin
        flag($sformatf("result with nothing expected: expected none, actual %h", d));
        return;
      end
      e = owed_q.pop_front();
      checked++;
      if ($isunknown(d)) begin
        flag($sformatf("unknown bits: expected known, actual %h", d));
        return;
      end
      compare("envelope_level", e.level, d[7:0]);
      compare("filter_bank", e.bank, d[13:8]);
      compare("lfo_mod", e.mod, $signed(d[21:14]));
      compare("stage", e.stage, d[23:22]);
      compare("finished", e.finished, d[24]);
      compare("tdata pad", 0, d[31:25]);
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;

  voice_scoreboard sb;
  bit              tx_quiet;
  int unsigned     items_sent;
  int unsigned     idle_cycles;
  int unsigned     n_settings;

  envelope_lfo_filter_index i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 2);
    if (p < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [39:0] rand40();
    logic [39:0] r;
    r[31:0] = $urandom;
    r[39:32] = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic logic [23:0] pick_gate();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 20) return 24'($urandom_range(0, 3));
    if (p < 90) return 24'($urandom_range(4, 60));
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic logic [23:0] pick_step(int unsigned hi);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 24'd0;
    if (p < 15) return 24'hFFFFFF;
    return 24'($urandom_range(24'h2000, hi));
  endfunction

  function automatic logic [7:0] pick_level();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) return 8'd0;
    if (p < 25) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void roll_config(output logic [23:0] vals [8], input bit one_shot);
    vals[CFG_STAGE_LEVELS] = {pick_level(), pick_level(), pick_level()};
    vals[CFG_STEP_ATTACK]  = pick_step(24'h300000);
    vals[CFG_STEP_DECAY]   = pick_step(24'h300000);
    vals[CFG_STEP_SUSTAIN] = pick_step(24'h300000);
    vals[CFG_STEP_RELEASE] = pick_step(24'h300000);
    vals[CFG_LFO_STEP]     = pick_step(24'h800000);
    vals[CFG_FILTER_SETUP] = 24'($urandom_range(0, 24'hFFFFFF));
    vals[CFG_LFO_ONE_SHOT] = {23'd0, one_shot};
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [39:0] data);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd != CmdUnused) items_sent++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, rand40());
  endtask

  task automatic send_note(logic [23:0] gate);
    logic [39:0] d;
    d = rand40();
    d[23:0] = gate;
    send_item(CMD_NOTE_ON, d);
  endtask

  task automatic send_table(logic [7:0] idx, logic [7:0] val);
    logic [39:0] d;
    d = rand40();
    d[31:24] = idx;
    d[39:32] = val;
    send_item(CMD_TABLE_WR, d);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [23:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned stop, kind;
    stop = items_sent + budget;
    tx_quiet = 1'b0;
    // ticks first, on whatever state the previous setting left behind
    repeat ($urandom_range(1, 10)) send_tick();
    while (items_sent < stop) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 62) begin
        send_note(pick_gate());
        repeat ($urandom_range(4, 70)) send_tick();
      end else if (kind < 76) begin
        repeat ($urandom_range(1, 4)) begin
          send_table(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 20)) send_tick();
      end else if (kind < 96) begin
        send_item(2'($urandom_range(0, 3)), rand40());
      end else if (kind < 98) begin
        send_item(CmdUnused, rand40());
      end else begin
        wait_drained();
      end
    end
  endtask

  // input and result monitor, plus the no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_out(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.take_item(s_axis_tuser, s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, sb.pending());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, quiet stretches, and a long hold-off now and then
  initial begin : rx_side
    int unsigned stall_left, free_left, n_rx, next_hold, p;
    m_axis_tready = 1'b0;
    stall_left = 0;
    free_left = 0;
    n_rx = 0;
    next_hold = HoldEvery;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) n_rx++;
      if (n_rx >= next_hold) begin
        next_hold += HoldEvery;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (free_left != 0) begin
        free_left--;
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 4) begin
          free_left = $urandom_range(30, 250);
          m_axis_tready <= 1'b1;
        end else if (p < 30) begin
          stall_left = pick_gap();
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : stim
    logic [23:0] cfg [8];
    logic [7:0]  v;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_STAGE_LEVELS;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_TICK;
    tx_quiet = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    n_settings = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole LFO table first so no tick ever reads an unwritten entry
    for (int i = 0; i < ModDepth; i++) begin
      case (i)
        0:       v = 8'h80;
        1:       v = 8'h7F;
        2:       v = 8'h00;
        3:       v = 8'hFF;
        default: v = 8'($urandom_range(0, 255));
      endcase
      send_table(i[7:0], v);
    end
    wait_drained();

    // directed: attack 255 in 4 ticks, decay to 160, sustain parked on a zero step
    cfg = '{24'h50A0FF, 24'h400000, 24'h100000, 24'h000000,
            24'h200000, 24'h100000, 24'hFF8020, 24'h000000};
    load_config(cfg);
    send_tick();                // gate never loaded, so straight to release
    send_note(24'd0);
    send_tick();
    send_note(24'hFFFFFF);
    repeat (10) send_tick();
    send_table(8'd0, 8'h80);
    send_table(8'd255, 8'h7F);
    send_item(CmdUnused, '1);
    send_note(24'd3);
    repeat (6) send_tick();
    wait_drained();

    // all registers at their top value: one-shot LFO freezes at once
    foreach (cfg[i]) cfg[i] = 24'hFFFFFF;
    load_config(cfg);
    run_random(110);
    wait_drained();

    // all zero: LFO off, envelope stuck unless already on target
    foreach (cfg[i]) cfg[i] = 24'h000000;
    load_config(cfg);
    run_random(70);
    wait_drained();

    // alternating one-shot and loop so a frozen LFO meets a mode change
    for (int p = 3; p < 11; p++) begin
      roll_config(cfg, p[0]);
      load_config(cfg);
      run_random(120);
      wait_drained();
    end

    $display("summary: %0d ticks, %0d note-ons, %0d table writes, %0d unused commands",
             sb.n_tick, sb.n_note, sb.n_wr, sb.n_unused);
    $display("summary: %0d results checked over %0d settings, %0d gate releases, %0d freezes",
             sb.checked, n_settings, sb.n_gate_rel, sb.n_freeze);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
